// ----- rtl/btlv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and constants of the BER-TLV header parser: byte kinds,
// error codes, parse phases and the packing of the result item.
// ----------------------------------------------------------------------------
package btlv_pkg;

   // default limit on the number of long-form length octets
   localparam int LengthOctetsMaxDefault = 4;

   // field widths
   localparam int DataWidth   = 8;
   localparam int KindWidth   = 3;
   localparam int ClassWidth  = 2;
   localparam int LowWidth    = 5;
   localparam int LengthWidth = 32;
   localparam int ErrorWidth  = 2;
   localparam int PhaseWidth  = 3;

   // result tdata: 43 bits of fields, padded to whole bytes
   localparam int RspFieldBits = ClassWidth + 1 + LowWidth + LengthWidth + 1 + ErrorWidth;
   localparam int RspDataWidth = ((RspFieldBits + 7) / 8) * 8;

   // byte kinds
   localparam logic [KindWidth-1:0] KIND_PADDING   = 3'd0;
   localparam logic [KindWidth-1:0] KIND_TAG_FIRST = 3'd1;
   localparam logic [KindWidth-1:0] KIND_TAG_CONT  = 3'd2;
   localparam logic [KindWidth-1:0] KIND_LEN_SHORT = 3'd3;
   localparam logic [KindWidth-1:0] KIND_LEN_COUNT = 3'd4;
   localparam logic [KindWidth-1:0] KIND_LEN_OCTET = 3'd5;
   localparam logic [KindWidth-1:0] KIND_VALUE     = 3'd6;
   localparam logic [KindWidth-1:0] KIND_ERROR     = 3'd7;

   // error codes
   localparam logic [ErrorWidth-1:0] ERR_NONE       = 2'd0;
   localparam logic [ErrorWidth-1:0] ERR_TOO_LONG   = 2'd1;
   localparam logic [ErrorWidth-1:0] ERR_INDEFINITE = 2'd2;
   localparam logic [ErrorWidth-1:0] ERR_TRUNCATED  = 2'd3;

   // parse phases
   localparam logic [PhaseWidth-1:0] PH_IDLE     = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_TAG_CONT = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_LEN_FIRST = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_LEN_OCT  = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_VALUE    = 3'd4;

   // byte constants
   localparam logic [DataWidth-1:0] BYTE_PAD_ZERO  = 8'h00;
   localparam logic [DataWidth-1:0] BYTE_PAD_ONES  = 8'hFF;
   localparam logic [DataWidth-1:0] BYTE_INDEF_LEN = 8'h80;
   localparam logic [LowWidth-1:0]  TAG_LOW_ESCAPE = 5'd31;

   // one result item
   typedef struct packed {
      logic [ErrorWidth-1:0]  error_code;
      logic                   length_done;
      logic [LengthWidth-1:0] length_value;
      logic [LowWidth-1:0]    tag_low_number;
      logic                   is_constructed;
      logic [ClassWidth-1:0]  tag_class;
   } rsp_fields_type;

endpackage

// ----- rtl/ber_tlv_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_header_parser
// Byte-serial BER-TLV header classifier with one result item per input byte.
// ----------------------------------------------------------------------------
// Takes one byte of a BER-TLV buffer per item and returns one result item per
// byte that classifies it (padding, tag, length, value or error) and carries
// the decoded tag class, constructed bit, low tag number and length. Padding
// bytes 0x00 and 0xFF are skipped between objects; a constructed object's
// content is parsed as further tags. A byte with tlast set closes the buffer:
// an unfinished object then reports a truncation error, and the parser starts
// again from idle. The phase and counter update is done in the cycle the
// byte is accepted and the result lands in the output register, so a byte
// can be taken in every cycle while the result side keeps up; a stalled
// result is held while the next byte waits on req_tready.
module ber_tlv_header_parser #(
   parameter int LENGTH_OCTETS_MAX = btlv_pkg::LengthOctetsMaxDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [btlv_pkg::DataWidth-1:0]    req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // last_byte
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] tag_class, [2] is_constructed, [7:3] tag_low_number,
   // [39:8] length_value, [40] length_done, [42:41] error_code, rest zero
   output logic [btlv_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic [btlv_pkg::KindWidth-1:0]    rsp_tuser    // [2:0] byte_kind
);
   import btlv_pkg::*;

   localparam int OctCountWidth = $clog2(LENGTH_OCTETS_MAX + 1);

   // parser state
   logic [PhaseWidth-1:0]    phase_ff, phase_in;
   logic                     cons_ff, cons_in;
   logic [OctCountWidth-1:0] oct_left_ff, oct_left_in;
   logic [LengthWidth-1:0]   acc_ff, acc_in;
   logic [LengthWidth-1:0]   value_left_ff, value_left_in;

   // result register
   logic                     rsp_valid_ff;
   logic [KindWidth-1:0]     kind_ff, kind_in;
   rsp_fields_type           fields_ff, fields_in;

   logic                     accept;
   logic                     owed;
   logic [LengthWidth-1:0]   len_dec;
   logic [LengthWidth-1:0]   acc_next;
   logic [LengthWidth-1:0]   value_next;
   logic [OctCountWidth-1:0] oct_next;
   logic [DataWidth-2:0]     count_field;

   // handshake: the output register frees up as its item is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign count_field = req_tdata[DataWidth-2:0];
   assign acc_next    = {acc_ff[LengthWidth-DataWidth-1:0], req_tdata};
   assign value_next  = value_left_ff - LengthWidth'(1);
   assign oct_next    = oct_left_ff - OctCountWidth'(1);

   // per-byte classification and next state
   always_comb begin
      phase_in      = phase_ff;
      cons_in       = cons_ff;
      oct_left_in   = oct_left_ff;
      acc_in        = acc_ff;
      value_left_in = value_left_ff;
      kind_in       = KIND_PADDING;
      fields_in     = '0;
      owed          = 1'b0;
      len_dec       = '0;

      unique case (phase_ff)
         PH_TAG_CONT: begin
            kind_in                  = KIND_TAG_CONT;
            fields_in.is_constructed = cons_ff;
            if (!req_tdata[DataWidth-1]) begin
               phase_in = PH_LEN_FIRST;
            end
            owed = 1'b1;
         end
         PH_LEN_FIRST: begin
            fields_in.is_constructed = cons_ff;
            if (!req_tdata[DataWidth-1]) begin
               kind_in = KIND_LEN_SHORT;
               len_dec = LengthWidth'(count_field);
            end else if (req_tdata == BYTE_INDEF_LEN) begin
               kind_in              = KIND_ERROR;
               fields_in.error_code = ERR_INDEFINITE;
            end else if (32'(count_field) > 32'(LENGTH_OCTETS_MAX)) begin
               kind_in              = KIND_ERROR;
               fields_in.error_code = ERR_TOO_LONG;
            end else begin
               kind_in     = KIND_LEN_COUNT;
               oct_left_in = OctCountWidth'(count_field);
               acc_in      = '0;
               phase_in    = PH_LEN_OCT;
               owed        = 1'b1;
            end
         end
         PH_LEN_OCT: begin
            fields_in.is_constructed = cons_ff;
            if (acc_ff[LengthWidth-1:LengthWidth-DataWidth] != '0) begin
               kind_in              = KIND_ERROR;
               fields_in.error_code = ERR_TOO_LONG;
            end else begin
               kind_in                = KIND_LEN_OCTET;
               acc_in                 = acc_next;
               oct_left_in            = oct_next;
               fields_in.length_value = acc_next;
               len_dec                = acc_next;
               if (oct_next != '0) begin
                  owed = 1'b1;
               end
            end
         end
         PH_VALUE: begin
            kind_in                  = KIND_VALUE;
            fields_in.is_constructed = cons_ff;
            value_left_in            = value_next;
            if (value_next == '0) begin
               phase_in = PH_IDLE;
            end else begin
               owed = 1'b1;
            end
         end
         default: begin
            if (req_tdata == BYTE_PAD_ZERO || req_tdata == BYTE_PAD_ONES) begin
               kind_in = KIND_PADDING;
            end else begin
               kind_in                  = KIND_TAG_FIRST;
               fields_in.tag_class      = req_tdata[DataWidth-1:DataWidth-ClassWidth];
               fields_in.is_constructed = req_tdata[LowWidth];
               fields_in.tag_low_number = req_tdata[LowWidth-1:0];
               cons_in                  = req_tdata[LowWidth];
               phase_in = (req_tdata[LowWidth-1:0] == TAG_LOW_ESCAPE) ?
                          PH_TAG_CONT : PH_LEN_FIRST;
               owed     = 1'b1;
            end
         end
      endcase

      // length field complete: value phase for a primitive with content
      if (kind_in == KIND_LEN_SHORT ||
          (kind_in == KIND_LEN_OCTET && oct_next == '0)) begin
         fields_in.length_done  = 1'b1;
         fields_in.length_value = len_dec;
         oct_left_in            = '0;
         acc_in                 = '0;
         if (cons_ff || len_dec == '0) begin
            phase_in      = PH_IDLE;
            value_left_in = '0;
            owed          = (len_dec != '0);
         end else begin
            phase_in      = PH_VALUE;
            value_left_in = len_dec;
            owed          = 1'b1;
         end
      end

      // buffer ends with an object open
      if (kind_in != KIND_ERROR && req_tlast && owed) begin
         kind_in              = KIND_ERROR;
         fields_in.error_code = ERR_TRUNCATED;
      end

      // errors carry only the code; errors and last bytes restart the parser
      if (kind_in == KIND_ERROR) begin
         fields_in.tag_class      = '0;
         fields_in.is_constructed = 1'b0;
         fields_in.tag_low_number = '0;
         fields_in.length_value   = '0;
         fields_in.length_done    = 1'b0;
      end
      if (kind_in == KIND_ERROR || req_tlast) begin
         phase_in      = PH_IDLE;
         cons_in       = 1'b0;
         oct_left_in   = '0;
         acc_in        = '0;
         value_left_in = '0;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cons_ff       <= 1'b0;
         oct_left_ff   <= '0;
         acc_ff        <= '0;
         value_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            cons_ff       <= cons_in;
            oct_left_ff   <= oct_left_in;
            acc_ff        <= acc_in;
            value_left_ff <= value_left_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         fields_ff <= fields_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = RspDataWidth'(fields_ff);

`ifndef SYNTHESIS
   // an error code only travels with an error item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != KIND_ERROR |-> fields_ff.error_code == ERR_NONE)
      else $error("error code on a non-error item");

   // a last byte always leaves the parser idle
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == PH_IDLE && value_left_ff == '0)
      else $error("parser not idle after last byte");

   // value phase always has bytes outstanding
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> value_left_ff != '0 && !cons_ff)
      else $error("value phase without outstanding bytes");

   // the length octet counter only runs in the length octet phase
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_LEN_OCT |-> oct_left_ff == '0)
      else $error("length octet count outside length phase");
`endif

endmodule
